[hw/rtl/dsa_pkg.sv]
// Shared types and constants for the descriptor slot allocator.
// Holds field widths, status and configuration register codes, and parameter defaults.
// No dependencies.
package dsa_pkg;

    // Default sizing of the allocator.
    localparam int DEF_MAX_SLOTS     = 1024;
    localparam int DEF_ADDRESS_BITS  = 48;

    // Fixed field widths.
    localparam int CAP_W      = 11;
    localparam int STRIDE_W   = 13;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;

    // Reset value of the stride register.
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE  = 3'd4;

    // Request operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BELOW = 2'd2,
        ST_DROP  = 2'd3
    } status_t;

endpackage

[hw/rtl/descriptor_slot_allocator.sv]
// Descriptor slot allocator top level: fresh-index counter plus a FIFO free list
// held in a synchronous memory, with an iterative divider for address-to-index.
// Depends on dsa_pkg.
//
//   Channel  | Direction | Handshake            | Payload
//   ---------+-----------+----------------------+-------------------------------------
//   s_       | in        | s_valid / s_ready    | s_operation, s_release_address
//   m_       | out       | m_valid / m_ready    | m_status, m_cpu_address, m_gpu_address
//   cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request is in flight at a time. An allocate that finds room goes through S_MUL
// and S_ADD to a loaded result in S_RESP (through S_READ first when it reuses a freed
// index, for the free-list memory read). A free that is kept goes through S_CHECK,
// S_RANGE, S_DIV, where the divider gives one quotient bit per cycle, and S_PUSH. The
// result register lets a new request be accepted while the previous result waits; a
// stalled m_ready holds the finished request in its last state. Reset is synchronous
// and needs no clearing pass: free-list entries are read only after they are written.
module descriptor_slot_allocator #(
    parameter int MAX_SLOTS    = dsa_pkg::DEF_MAX_SLOTS,
    parameter int ADDRESS_BITS = dsa_pkg::DEF_ADDRESS_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic [ADDRESS_BITS-1:0]        s_release_address,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dsa_pkg::STATUS_W-1:0]   m_status,
    output logic [ADDRESS_BITS-1:0]        m_cpu_address,
    output logic [ADDRESS_BITS-1:0]        m_gpu_address,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDRESS_BITS-1:0]        cfg_data
);
    import dsa_pkg::*;

    localparam int IDX_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int CAPX_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int PROD_W  = IDX_W + STRIDE_W;
    localparam int SUM_W   = (ADDRESS_BITS > PROD_W) ? ADDRESS_BITS : PROD_W;
    localparam int DIV_W   = CNT_W + STRIDE_W;
    localparam int CMP_W   = (ADDRESS_BITS > DIV_W) ? ADDRESS_BITS : DIV_W;
    localparam int STEP_W  = $clog2(IDX_W + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_READ  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_ADD   = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_RANGE = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_PUSH  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    // Control state.
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          fresh_reg, fresh_next;
    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      m_valid_reg, m_valid_next;

    // Configuration registers.
    logic [CAP_W-1:0]          cap_reg;
    logic [STRIDE_W-1:0]       stride_reg;
    logic [ADDRESS_BITS-1:0]   cpu_base_reg;
    logic [ADDRESS_BITS-1:0]   gpu_base_reg;
    logic                      visible_reg;

    // Datapath registers.
    logic [ADDRESS_BITS-1:0]   addr_reg, addr_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [ADDRESS_BITS-1:0]   off_reg, off_next;
    logic [DIV_W-1:0]          limit_reg, limit_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [DIV_W-1:0]          dsh_reg, dsh_next;
    logic [IDX_W-1:0]          quot_reg, quot_next;
    status_t                   res_status_reg, res_status_next;
    logic [ADDRESS_BITS-1:0]   res_cpu_reg, res_cpu_next;
    logic [ADDRESS_BITS-1:0]   res_gpu_reg, res_gpu_next;
    status_t                   m_status_reg, m_status_next;
    logic [ADDRESS_BITS-1:0]   m_cpu_reg, m_cpu_next;
    logic [ADDRESS_BITS-1:0]   m_gpu_reg, m_gpu_next;

    // Free-list memory.
    logic [IDX_W-1:0]          queue_mem [MAX_SLOTS];
    logic [IDX_W-1:0]          rd_data_reg;
    logic                      mem_re;
    logic                      mem_we;

    // Helpers.
    logic [CNT_W-1:0]          eff_cap;
    logic [SUM_W-1:0]          cpu_sum;
    logic [SUM_W-1:0]          gpu_sum;
    logic                      div_take;
    logic                      s_fire;

    // Capacity saturates at the size of the free list.
    assign eff_cap = (CAPX_W'(cap_reg) > CAPX_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                              : CNT_W'(cap_reg);

    assign cpu_sum  = SUM_W'(cpu_base_reg) + SUM_W'(prod_reg);
    assign gpu_sum  = SUM_W'(gpu_base_reg) + SUM_W'(prod_reg);
    assign div_take = (rem_reg >= dsh_reg);

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_cpu_address = m_cpu_reg;
    assign m_gpu_address = m_gpu_reg;

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next      = state_reg;
        fresh_next      = fresh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        step_next       = step_reg;
        m_valid_next    = m_valid_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        off_next        = off_reg;
        limit_next      = limit_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        quot_next       = quot_reg;
        res_status_next = res_status_reg;
        res_cpu_next    = res_cpu_reg;
        res_gpu_next    = res_gpu_reg;
        m_status_next   = m_status_reg;
        m_cpu_next      = m_cpu_reg;
        m_gpu_next      = m_gpu_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;

        // The result register empties when its beat is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    addr_next       = s_release_address;
                    res_status_next = ST_OK;
                    res_cpu_next    = '0;
                    res_gpu_next    = '0;
                    if (s_operation == OP_FREE) begin
                        state_next = S_CHECK;
                    end else if (fill_reg != '0) begin
                        // Reuse the oldest freed index.
                        mem_re     = 1'b1;
                        head_next  = (head_reg == IDX_W'(MAX_SLOTS - 1)) ? '0
                                                                        : head_reg + 1'b1;
                        fill_next  = fill_reg - 1'b1;
                        state_next = S_READ;
                    end else if (fresh_reg >= eff_cap) begin
                        res_status_next = ST_FULL;
                        state_next      = S_RESP;
                    end else begin
                        idx_next   = fresh_reg[IDX_W-1:0];
                        fresh_next = fresh_reg + 1'b1;
                        state_next = S_MUL;
                    end
                end
            end

            S_READ: begin
                idx_next   = rd_data_reg;
                state_next = S_MUL;
            end

            S_MUL: begin
                prod_next  = PROD_W'(idx_reg) * PROD_W'(stride_reg);
                state_next = S_ADD;
            end

            S_ADD: begin
                res_cpu_next = cpu_sum[ADDRESS_BITS-1:0];
                res_gpu_next = visible_reg ? gpu_sum[ADDRESS_BITS-1:0] : '0;
                state_next   = S_RESP;
            end

            S_CHECK: begin
                // Offset from the base, and the first offset past the last slot.
                if (addr_reg < cpu_base_reg) begin
                    res_status_next = ST_BELOW;
                    state_next      = S_RESP;
                end else begin
                    off_next   = addr_reg - cpu_base_reg;
                    limit_next = DIV_W'(eff_cap) * DIV_W'(stride_reg);
                    state_next = S_RANGE;
                end
            end

            S_RANGE: begin
                // A zero stride or zero capacity gives a zero limit, so it drops here.
                if ((CMP_W'(off_reg) >= CMP_W'(limit_reg)) ||
                    (fill_reg == CNT_W'(MAX_SLOTS))) begin
                    res_status_next = ST_DROP;
                    state_next      = S_RESP;
                end else begin
                    rem_next   = DIV_W'(off_reg);
                    dsh_next   = DIV_W'(stride_reg) << (IDX_W - 1);
                    quot_next  = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV: begin
                // Restoring division, one quotient bit per cycle, MSB first.
                if (div_take) begin
                    rem_next = rem_reg - dsh_reg;
                end
                quot_next = IDX_W'({quot_reg, div_take});
                dsh_next  = dsh_reg >> 1;
                if (step_reg == '0) begin
                    state_next = S_PUSH;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end

            S_PUSH: begin
                mem_we     = 1'b1;
                tail_next  = (tail_reg == IDX_W'(MAX_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                fill_next  = fill_reg + 1'b1;
                state_next = S_RESP;
            end

            S_RESP: begin
                // Load the result register once it is free or being emptied.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_cpu_next    = res_cpu_reg;
                    m_gpu_next    = res_gpu_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fresh_reg    <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            step_reg     <= '0;
            m_valid_reg  <= 1'b0;
            cap_reg      <= '0;
            stride_reg   <= STRIDE_RESET;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            visible_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fresh_reg   <= fresh_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CAPACITY: cap_reg      <= cfg_data[CAP_W-1:0];
                    CFG_STRIDE:   stride_reg   <= cfg_data[STRIDE_W-1:0];
                    CFG_CPU_BASE: cpu_base_reg <= cfg_data;
                    CFG_GPU_BASE: gpu_base_reg <= cfg_data;
                    CFG_VISIBLE:  visible_reg  <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        off_reg        <= off_next;
        limit_reg      <= limit_next;
        rem_reg        <= rem_next;
        dsh_reg        <= dsh_next;
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_cpu_reg    <= res_cpu_next;
        res_gpu_reg    <= res_gpu_next;
        m_status_reg   <= m_status_next;
        m_cpu_reg      <= m_cpu_next;
        m_gpu_reg      <= m_gpu_next;
    end

    // Free-list memory: one write port at the tail, one registered read at the head.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            queue_mem[tail_reg] <= quot_reg;
        end
        if (mem_re) begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

endmodule
